// File: hdl/mbfc_pkg.sv
// Package for the MBF / IEEE 754 converter.
// Holds the operation codes and the bias and pattern constants; depends on nothing.
package mbfc_pkg;

  // Operation codes carried on the kind port.
  typedef enum logic [1:0] {
    KIND_ENC_SINGLE = 2'd0,
    KIND_ENC_DOUBLE = 2'd1,
    KIND_DEC_SINGLE = 2'd2,
    KIND_DEC_DOUBLE = 2'd3
  } kind_t;

  // Exponent re-bias amounts and range limits between IEEE and MBF layouts.
  localparam logic [7:0]  SGL_BIAS_DELTA = 8'd2;
  localparam logic [10:0] DBL_BIAS_DELTA = 11'd894;
  localparam logic [10:0] DBL_EXP_UFLOW  = 11'd894;
  localparam logic [10:0] DBL_EXP_OFLOW  = 11'd1149;
  localparam logic [7:0]  SGL_EXP_OFLOW  = 8'd253;

  // Fixed result patterns.
  localparam logic [63:0] SGL_MBF_NAN    = 64'h0000_0000_FF00_0000;
  localparam logic [63:0] SGL_MBF_MAX    = 64'h0000_0000_FF7F_FFFF;
  localparam logic [63:0] DBL_MBF_NAN    = 64'hFF00_0000_0000_0000;
  localparam logic [63:0] DBL_MBF_MAX    = 64'hFF7F_FFFF_FFFF_FFFF;
  localparam logic [63:0] SGL_IEEE_QNAN  = 64'h0000_0000_7FC0_0000;
  localparam logic [63:0] SGL_IEEE_INF   = 64'h0000_0000_7F80_0000;
  localparam logic [63:0] DBL_IEEE_QNAN  = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] DBL_IEEE_INF   = 64'h7FF0_0000_0000_0000;

endpackage

// File: hdl/mbf_ieee_float_converter_unit.sv
// Converter between IEEE 754 patterns and the MBF layout, one word per transaction.
// A word taken into the input register is converted and caught in the result register, which raises done.
// Throughput: one transaction every cycle; busy stays low, as the work is one registered pass.
// Reset: synchronous rst clears the valid flags of the input and result registers.
// Depends on mbfc_pkg.
module mbf_ieee_float_converter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [63:0] operand_bits,
  output logic        done,
  output logic [63:0] converted_bits
);

  // Input register.
  logic               in_valid;
  mbfc_pkg::kind_t    kind_q;
  logic [63:0]        operand_q;
  logic [63:0]        converted_next;

  // Field views of the registered operand.
  logic        ss_sign, sd_sign, ms_sign, md_sign;
  logic [7:0]  ss_exp, ms_exp, md_exp;
  logic [10:0] sd_exp;
  logic [22:0] ss_man, ms_man;
  logic [51:0] sd_man;
  logic [54:0] md_man;
  logic [10:0] sd_exp_reb;
  logic [7:0]  ms_exp_reb;
  logic [10:0] md_exp_reb;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
    kind_q    <= mbfc_pkg::kind_t'(kind);
    operand_q <= operand_bits;
  end

  // IEEE fields for encoding.
  assign ss_sign    = operand_q[31];
  assign ss_exp     = operand_q[30:23];
  assign ss_man     = operand_q[22:0];
  assign sd_sign    = operand_q[63];
  assign sd_exp     = operand_q[62:52];
  assign sd_man     = operand_q[51:0];
  assign sd_exp_reb = sd_exp - mbfc_pkg::DBL_BIAS_DELTA;

  // MBF fields for decoding.
  assign ms_sign    = operand_q[23];
  assign ms_exp     = operand_q[31:24];
  assign ms_man     = operand_q[22:0];
  assign md_sign    = operand_q[55];
  assign md_exp     = operand_q[63:56];
  assign md_man     = operand_q[54:0];
  assign ms_exp_reb = ms_exp - mbfc_pkg::SGL_BIAS_DELTA;
  assign md_exp_reb = {3'b000, md_exp} + mbfc_pkg::DBL_BIAS_DELTA;

  // Conversion of the registered word, one arm per operation.
  always_comb begin
    converted_next = '0;
    case (kind_q)
      mbfc_pkg::KIND_ENC_SINGLE: begin
        if (ss_exp == 8'hFF && ss_man != '0) begin
          converted_next = mbfc_pkg::SGL_MBF_NAN;
        end else if (ss_exp >= mbfc_pkg::SGL_EXP_OFLOW) begin
          converted_next = mbfc_pkg::SGL_MBF_MAX;
          converted_next[23] = ss_sign;
        end else if (ss_exp == '0 && ss_man == '0) begin
          converted_next[23] = ss_sign;
        end else begin
          converted_next[31:0] = {ss_exp + mbfc_pkg::SGL_BIAS_DELTA, ss_sign, ss_man};
        end
      end
      mbfc_pkg::KIND_ENC_DOUBLE: begin
        if (sd_exp == 11'h7FF && sd_man != '0) begin
          converted_next = mbfc_pkg::DBL_MBF_NAN;
        end else if (sd_exp <= mbfc_pkg::DBL_EXP_UFLOW) begin
          converted_next[55] = sd_sign;
        end else if (sd_exp >= mbfc_pkg::DBL_EXP_OFLOW) begin
          converted_next = mbfc_pkg::DBL_MBF_MAX;
          converted_next[55] = sd_sign;
        end else begin
          converted_next = {sd_exp_reb[7:0], sd_sign, sd_man, 3'b000};
        end
      end
      mbfc_pkg::KIND_DEC_SINGLE: begin
        if (ms_exp == 8'hFF) begin
          if (ms_man == '0) begin
            converted_next = mbfc_pkg::SGL_IEEE_QNAN;
          end else begin
            converted_next = mbfc_pkg::SGL_IEEE_INF;
            converted_next[31] = ms_sign;
          end
        end else if (ms_exp <= mbfc_pkg::SGL_BIAS_DELTA) begin
          converted_next[31] = ms_sign;
        end else begin
          converted_next[31:0] = {ms_sign, ms_exp_reb, ms_man};
        end
      end
      default: begin
        if (md_exp == 8'hFF) begin
          if (md_man == '0) begin
            converted_next = mbfc_pkg::DBL_IEEE_QNAN;
          end else begin
            converted_next = mbfc_pkg::DBL_IEEE_INF;
            converted_next[63] = md_sign;
          end
        end else if (md_exp == '0) begin
          converted_next[63] = md_sign;
        end else begin
          converted_next = {md_sign, md_exp_reb, md_man[54:3]};
        end
      end
    endcase
  end

  // Result register with its strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    converted_bits <= converted_next;
  end

  // Each result strobe traces back to one start that passed through the input and result registers.
  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2))
    else $error("done without a start two cycles earlier");

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    start ##1 !rst |=> done)
    else $error("start did not produce a result strobe");

  // Single-precision results keep the upper half clear.
  a_single_upper_zero: assert property (@(posedge clk) disable iff (rst)
    done && ($past(kind, 2) == mbfc_pkg::KIND_ENC_SINGLE ||
             $past(kind, 2) == mbfc_pkg::KIND_DEC_SINGLE)
      |-> converted_bits[63:32] == '0)
    else $error("single-precision result has upper bits set");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the MBF / IEEE 754 converter, with a start/busy command port.
// A directed table and then random words are driven; a predictor checks each done strobe.
// Depends on mbfc_pkg and mbf_ieee_float_converter_unit.
module tb_top;

  typedef struct {
    mbfc_pkg::kind_t k;
    logic [63:0]     op;
    bit              fixed;
    logic [63:0]     want;
  } vector_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  kind;
  logic [63:0] operand_bits;
  logic        done;
  logic [63:0] converted_bits;

  // Expected value typed into the table travels with the transaction.
  bit          row_fixed;
  logic [63:0] row_fixed_bits;

  logic [63:0] converted_due[$];
  int          mismatch_count = 0;
  vector_row_t plan[$];

  mbf_ieee_float_converter_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .operand_bits   (operand_bits),
    .done           (done),
    .converted_bits (converted_bits)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Independent model of the conversion for one word.
  function automatic logic [63:0] convert_word(mbfc_pkg::kind_t k, logic [63:0] op);
    logic        sgn;
    logic [7:0]  exp8;
    logic [10:0] exp11;
    logic [22:0] man23;
    logic [51:0] man52;
    logic [54:0] man55;
    logic [63:0] res;
    res = '0;
    case (k)
      mbfc_pkg::KIND_ENC_SINGLE: begin
        sgn   = op[31];
        exp8  = op[30:23];
        man23 = op[22:0];
        if (exp8 == 8'hFF && man23 != '0) begin
          res = 64'h0000_0000_FF00_0000;
        end else if (exp8 >= 8'd253) begin
          res = {32'h0, 8'hFF, sgn, 23'h7F_FFFF};
        end else if (exp8 == 8'd0 && man23 == '0) begin
          res = {32'h0, 8'h00, sgn, 23'h0};
        end else begin
          res = {32'h0, exp8 + 8'd2, sgn, man23};
        end
      end
      mbfc_pkg::KIND_ENC_DOUBLE: begin
        sgn   = op[63];
        exp11 = op[62:52];
        man52 = op[51:0];
        if (exp11 == 11'h7FF && man52 != '0) begin
          res = 64'hFF00_0000_0000_0000;
        end else if (exp11 <= 11'd894) begin
          res = {8'h00, sgn, 55'h0};
        end else if (exp11 > 11'd1148) begin
          res = {8'hFF, sgn, {55{1'b1}}};
        end else begin
          exp11 = exp11 - 11'd894;
          res   = {exp11[7:0], sgn, man52, 3'b000};
        end
      end
      mbfc_pkg::KIND_DEC_SINGLE: begin
        sgn   = op[23];
        exp8  = op[31:24];
        man23 = op[22:0];
        if (exp8 == 8'hFF) begin
          res = (man23 == '0) ? 64'h0000_0000_7FC0_0000 : {32'h0, sgn, 8'hFF, 23'h0};
        end else if (exp8 <= 8'd2) begin
          res = {32'h0, sgn, 31'h0};
        end else begin
          res = {32'h0, sgn, exp8 - 8'd2, man23};
        end
      end
      default: begin
        sgn   = op[55];
        exp8  = op[63:56];
        man55 = op[54:0];
        if (exp8 == 8'hFF) begin
          res = (man55 == '0) ? 64'h7FF8_0000_0000_0000 : {sgn, 11'h7FF, 52'h0};
        end else if (exp8 == 8'd0) begin
          res = {sgn, 63'h0};
        end else begin
          exp11 = {3'b000, exp8} + 11'd894;
          res   = {sgn, exp11, man55[54:3]};
        end
      end
    endcase
    return res;
  endfunction

  // Random word, in six cases out of ten with the exponent pushed onto a range boundary.
  function automatic logic [63:0] random_operand(mbfc_pkg::kind_t k);
    logic [63:0] w;
    int          pick;
    w    = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick >= 6) return w;
    case (k)
      mbfc_pkg::KIND_ENC_SINGLE: begin
        case (pick)
          0: w[30:23] = 8'd0;
          1: w[30:23] = 8'd1;
          2: w[30:23] = 8'd252;
          3: w[30:23] = 8'd253;
          4: w[30:23] = 8'd254;
          default: w[30:23] = 8'd255;
        endcase
        if ($urandom_range(0, 3) == 0) w[22:0] = '0;
      end
      mbfc_pkg::KIND_ENC_DOUBLE: begin
        case (pick)
          0: w[62:52] = 11'd0;
          1: w[62:52] = 11'd894;
          2: w[62:52] = 11'd895;
          3: w[62:52] = 11'd1148;
          4: w[62:52] = 11'd1149;
          default: w[62:52] = 11'd2047;
        endcase
        if ($urandom_range(0, 3) == 0) w[51:0] = '0;
      end
      mbfc_pkg::KIND_DEC_SINGLE: begin
        case (pick)
          0: w[31:24] = 8'd0;
          1: w[31:24] = 8'd1;
          2: w[31:24] = 8'd2;
          3: w[31:24] = 8'd3;
          4: w[31:24] = 8'd254;
          default: w[31:24] = 8'd255;
        endcase
        if ($urandom_range(0, 3) == 0) w[22:0] = '0;
      end
      default: begin
        case (pick)
          0: w[63:56] = 8'd0;
          1: w[63:56] = 8'd1;
          2: w[63:56] = 8'd2;
          3: w[63:56] = 8'd128;
          4: w[63:56] = 8'd254;
          default: w[63:56] = 8'd255;
        endcase
        if ($urandom_range(0, 3) == 0) w[54:0] = '0;
      end
    endcase
    return w;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(mbfc_pkg::kind_t k, logic [63:0] op, bit fixed,
                                  logic [63:0] want);
    plan.push_back('{k, op, fixed, want});
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 50) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Present one transaction and hold it until the converter takes it.
  task automatic send_word(mbfc_pkg::kind_t k, logic [63:0] op, bit fixed,
                           logic [63:0] want);
    start          <= 1'b1;
    kind           <= k;
    operand_bits   <= op;
    row_fixed      <= fixed;
    row_fixed_bits <= want;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drop start for some cycles, with junk on the payload ports meanwhile.
  task automatic idle_sender(int cycles);
    if (cycles > 0) begin
      start        <= 1'b0;
      kind         <= 2'($urandom);
      operand_bits <= {$urandom, $urandom};
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Mostly back to back, sometimes short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Stop sending until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (converted_due.size() != 0);
    @(posedge clk);
  endtask

  // Result checking and capture of accepted transactions, both at the rising edge.
  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst) begin
      if ($isunknown(done)) begin
        report_mismatch("done is unknown");
      end else if (done) begin
        if (converted_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", converted_bits));
        end else begin
          want = converted_due.pop_front();
          if (converted_bits !== want)
            report_mismatch($sformatf("converted_bits %h, expected %h", converted_bits, want));
        end
      end
      if (start && busy === 1'b0) begin
        want = row_fixed ? row_fixed_bits
                         : convert_word(mbfc_pkg::kind_t'(kind), operand_bits);
        converted_due.push_back(want);
      end
    end
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    mbfc_pkg::kind_t k;
    // Directed table: zeros, NaNs, infinities, range boundaries and stray upper bits.
    add_row(mbfc_pkg::KIND_ENC_SINGLE, 64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000);
    add_row(mbfc_pkg::KIND_ENC_SINGLE, 64'h0000_0000_8000_0000, 1'b1, 64'h0000_0000_0080_0000);
    add_row(mbfc_pkg::KIND_ENC_SINGLE, 64'h0000_0000_7FC0_0000, 1'b1, 64'h0000_0000_FF00_0000);
    add_row(mbfc_pkg::KIND_ENC_SINGLE, 64'h0000_0000_7F80_0000, 1'b1, 64'h0000_0000_FF7F_FFFF);
    add_row(mbfc_pkg::KIND_ENC_SINGLE, 64'h0000_0000_FF80_0000, 1'b1, 64'h0000_0000_FFFF_FFFF);
    add_row(mbfc_pkg::KIND_ENC_SINGLE, 64'h0000_0000_7F7F_FFFF, 1'b1, 64'h0000_0000_FF7F_FFFF);
    add_row(mbfc_pkg::KIND_ENC_SINGLE, 64'h0000_0000_7E7F_FFFF, 1'b0, 64'h0);
    add_row(mbfc_pkg::KIND_ENC_SINGLE, 64'h0000_0000_0000_0001, 1'b0, 64'h0);
    add_row(mbfc_pkg::KIND_ENC_SINGLE, 64'hFFFF_FFFF_3F80_0000, 1'b0, 64'h0);
    add_row(mbfc_pkg::KIND_ENC_DOUBLE, 64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000);
    add_row(mbfc_pkg::KIND_ENC_DOUBLE, 64'h8000_0000_0000_0000, 1'b1, 64'h0080_0000_0000_0000);
    add_row(mbfc_pkg::KIND_ENC_DOUBLE, 64'h7FF8_0000_0000_0000, 1'b1, 64'hFF00_0000_0000_0000);
    add_row(mbfc_pkg::KIND_ENC_DOUBLE, 64'h7FF0_0000_0000_0000, 1'b1, 64'hFF7F_FFFF_FFFF_FFFF);
    add_row(mbfc_pkg::KIND_ENC_DOUBLE, 64'hFFF0_0000_0000_0000, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    add_row(mbfc_pkg::KIND_ENC_DOUBLE, 64'hB7EF_FFFF_FFFF_FFFF, 1'b0, 64'h0);
    add_row(mbfc_pkg::KIND_ENC_DOUBLE, 64'h37F0_0000_0000_0001, 1'b0, 64'h0);
    add_row(mbfc_pkg::KIND_ENC_DOUBLE, 64'h47CF_FFFF_FFFF_FFFF, 1'b0, 64'h0);
    add_row(mbfc_pkg::KIND_ENC_DOUBLE, 64'h47D0_0000_0000_0000, 1'b1, 64'hFF7F_FFFF_FFFF_FFFF);
    add_row(mbfc_pkg::KIND_DEC_SINGLE, 64'h0000_0000_FF00_0000, 1'b1, 64'h0000_0000_7FC0_0000);
    add_row(mbfc_pkg::KIND_DEC_SINGLE, 64'h0000_0000_FF80_0001, 1'b1, 64'h0000_0000_FF80_0000);
    add_row(mbfc_pkg::KIND_DEC_SINGLE, 64'h0000_0000_02FF_FFFF, 1'b1, 64'h0000_0000_8000_0000);
    add_row(mbfc_pkg::KIND_DEC_SINGLE, 64'hFFFF_FFFF_FEFF_FFFF, 1'b0, 64'h0);
    add_row(mbfc_pkg::KIND_DEC_DOUBLE, 64'hFF00_0000_0000_0000, 1'b1, 64'h7FF8_0000_0000_0000);
    add_row(mbfc_pkg::KIND_DEC_DOUBLE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFF0_0000_0000_0000);
    add_row(mbfc_pkg::KIND_DEC_DOUBLE, 64'h00FF_FFFF_FFFF_FFFF, 1'b1, 64'h8000_0000_0000_0000);
    add_row(mbfc_pkg::KIND_DEC_DOUBLE, 64'h0100_0000_0000_0007, 1'b0, 64'h0);

    rst            = 1'b1;
    start          = 1'b0;
    kind           = mbfc_pkg::KIND_ENC_SINGLE;
    operand_bits   = '0;
    row_fixed      = 1'b0;
    row_fixed_bits = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      send_word(plan[i].k, plan[i].op, plan[i].fixed, plan[i].want);
      idle_sender(pick_gap());
    end
    drain_results();

    // Random part, with a burst of back-to-back transactions in the middle.
    for (int n = 0; n < 500; n++) begin
      k = mbfc_pkg::kind_t'($urandom_range(0, 3));
      send_word(k, random_operand(k), 1'b0, 64'h0);
      if (n % 125 == 124) drain_results();
      else if (n < 200 || n >= 260) idle_sender(pick_gap());
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
